### hdl/lrupr_pkg.sv
// Shared constants and result type for the LRU page replacement block.
package lrupr_pkg;

  // Default number of resident frames
  localparam int FRAMES_DEF = 4;

  // Page number width
  localparam int PAGE_W = 16;

  // Width of the reported frame index
  localparam int FRAME_IDX_W = 2;

  // One result of a page request
  typedef struct packed {
    logic                   fault;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_W-1:0]      evicted_page;
  } rsp_t;

endpackage

### hdl/lrupr_if.sv
// Valid/ready channels for page requests and replacement results.
interface lrupr_req_if;
  logic                        valid;
  logic                        ready;
  logic [lrupr_pkg::PAGE_W-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink (input valid, input page, output ready);
endinterface

interface lrupr_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             fault;
  logic [lrupr_pkg::FRAME_IDX_W-1:0] frame_index;
  logic                             evicted_valid;
  logic [lrupr_pkg::PAGE_W-1:0]      evicted_page;

  modport source (output valid, output fault, output frame_index, output evicted_valid,
                  output evicted_page, input ready);
  modport sink (input valid, input fault, input frame_index, input evicted_valid,
                input evicted_page, output ready);
endinterface

### hdl/lru_page_replacement_top.sv
// Top level of the LRU page replacement block: sequencer and result register.
//
// Usage: page requests enter on the req channel (valid/ready, field page). Each
// request yields exactly one result on the rsp channel: fault, frame_index,
// evicted_valid and evicted_page (zero when nothing was evicted).
// The frame table (page and recency rank per frame) lives in one RAM with a
// registered read. A request runs a read pass over the filled frames to find
// a hit and the oldest frame, a decision state, then a read-modify-write pass
// that updates the ranks and the chosen frame. The next request is taken in
// the cycle after the result moves into the output register, so accesses to
// one entry never overlap.
// A finished result waits in the output register; the next request is
// accepted while it waits, and its own result holds until the register frees.
// Reset (rst, synchronous) empties the frame table: all frames are free and
// the RAM contents are not cleared, as the data of a free frame is never used.
module lru_page_replacement_top #(
  parameter int FRAMES = lrupr_pkg::FRAMES_DEF
) (
  input logic        clk,
  input logic        rst,
  lrupr_req_if.sink   req,
  lrupr_rsp_if.source rsp
);

  logic            res_valid;
  logic            res_room;
  lrupr_pkg::rsp_t res;
  lrupr_pkg::rsp_t out_q;
  logic            out_valid;

  lrupr_ctrl #(
    .FRAMES (FRAMES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_page   (req.page),
    .res_valid (res_valid),
    .res_room  (res_room),
    .res       (res)
  );

  assign res_room = !out_valid || rsp.ready;

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.fault         = out_q.fault;
  assign rsp.frame_index   = out_q.frame_index;
  assign rsp.evicted_valid = out_q.evicted_valid;
  assign rsp.evicted_page  = out_q.evicted_page;

endmodule

### hdl/lrupr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lrupr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/lrupr_ctrl.sv
// Request sequencer: scans the frame table, picks the frame and writes back ranks.
module lrupr_ctrl #(
  parameter int FRAMES = lrupr_pkg::FRAMES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lrupr_pkg::PAGE_W-1:0] in_page,
  output logic                         res_valid,
  input  logic                         res_room,
  output lrupr_pkg::rsp_t              res
);

  localparam int IW  = $clog2(FRAMES);
  localparam int RW  = IW;
  localparam int CW  = $clog2(FRAMES + 1);
  localparam int PW  = lrupr_pkg::PAGE_W;
  localparam int WW  = PW + RW;
  localparam int FIW = lrupr_pkg::FRAME_IDX_W;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t        state;
  logic [PW-1:0] page_q;
  logic [CW-1:0] filled;
  logic [CW-1:0] issue;
  logic [CW-1:0] limit;
  logic          rv;
  logic [IW-1:0] ridx;

  // Scan results
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [RW-1:0] hit_rank;
  logic          have_v;
  logic [IW-1:0] vic_idx;
  logic [RW-1:0] vic_rank;
  logic [PW-1:0] vic_page;

  // Decision for the write-back pass
  logic          fill_q;
  logic          was_valid;
  logic [IW-1:0] f_q;
  logic [RW-1:0] rf;
  logic          fault_q;
  logic          ev_q;
  logic [PW-1:0] ev_page_q;

  // Memory port
  logic          issue_go;
  logic          we;
  logic [WW-1:0] wdata;
  logic [WW-1:0] rdata;
  logic [PW-1:0] rd_page;
  logic [RW-1:0] rd_rank;
  logic [RW-1:0] new_rank;

  assign issue_go = ((state == ST_SCAN) || (state == ST_UPDATE)) && (issue < limit);
  assign rd_page  = rdata[WW-1:RW];
  assign rd_rank  = rdata[RW-1:0];

  // Age every valid frame that was newer than the touched one (every frame on a fill)
  always_comb begin
    if (ridx == f_q) begin
      new_rank = '0;
    end else if (!was_valid || (rd_rank < rf)) begin
      new_rank = rd_rank + RW'(1);
    end else begin
      new_rank = rd_rank;
    end
  end

  // The touched frame always holds the requested page after write-back
  assign wdata = (ridx == f_q) ? {page_q, new_rank} : {rd_page, new_rank};
  assign we    = rv && (state == ST_UPDATE);

  lrupr_ram #(
    .WIDTH (WW),
    .DEPTH (FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (ridx),
    .wdata (wdata),
    .re    (issue_go),
    .raddr (issue[IW-1:0]),
    .rdata (rdata)
  );

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE) && res_room;
  assign res.fault         = fault_q;
  assign res.frame_index   = FIW'(f_q);
  assign res.evicted_valid = ev_q;
  assign res.evicted_page  = ev_page_q;

  // Read pipeline: the index of a read is registered alongside its data
  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else begin
      rv <= issue_go;
    end
    ridx <= issue[IW-1:0];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      filled <= '0;
      issue  <= '0;
      hit    <= 1'b0;
      have_v <= 1'b0;
    end else begin
      if (issue_go) begin
        issue <= issue + CW'(1);
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            page_q <= in_page;
            issue  <= '0;
            limit  <= filled;
            hit    <= 1'b0;
            have_v <= 1'b0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rv) begin
            // Take the first match and the oldest frame, lowest index on ties
            if (!hit && (rd_page == page_q)) begin
              hit      <= 1'b1;
              hit_idx  <= ridx;
              hit_rank <= rd_rank;
            end
            if (!have_v || (rd_rank > vic_rank)) begin
              have_v   <= 1'b1;
              vic_idx  <= ridx;
              vic_rank <= rd_rank;
              vic_page <= rd_page;
            end
          end
          if (!issue_go && !rv) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          issue <= '0;
          state <= ST_UPDATE;
          if (hit) begin
            f_q       <= hit_idx;
            was_valid <= 1'b1;
            rf        <= hit_rank;
            fault_q   <= 1'b0;
            ev_q      <= 1'b0;
            ev_page_q <= '0;
            fill_q    <= 1'b0;
            limit     <= filled;
          end else if (filled < CW'(FRAMES)) begin
            // Fill the next free frame in order
            f_q       <= filled[IW-1:0];
            was_valid <= 1'b0;
            rf        <= '0;
            fault_q   <= 1'b1;
            ev_q      <= 1'b0;
            ev_page_q <= '0;
            fill_q    <= 1'b1;
            limit     <= filled + CW'(1);
          end else begin
            // Replace the least recently used frame
            f_q       <= vic_idx;
            was_valid <= 1'b1;
            rf        <= vic_rank;
            fault_q   <= 1'b1;
            ev_q      <= 1'b1;
            ev_page_q <= vic_page;
            fill_q    <= 1'b0;
            limit     <= filled;
          end
        end
        ST_UPDATE: begin
          if (!issue_go && !rv) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_room) begin
            if (fill_q) begin
              filled <= filled + CW'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
